// ----- src/mex_pkg.sv -----
// Shared constants, payload types and codes for the mex-tracking multiset.
`timescale 1ns / 1ps

package mex_pkg;

    localparam int VALUE_W  = 10;
    localparam int MEX_W    = 11;
    localparam int STATUS_W = 2;

    localparam int DEF_VALUE_SPACE = 1024;
    localparam int DEF_BLOCK_SIZE  = 32;
    localparam int DEF_COUNT_WIDTH = 16;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_ABSENT = 2'd1,
        STAT_SAT    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_ROW,
        ST_SCAN
    } t_state;

    // change to the presence bit of one value
    typedef struct packed {
        logic upd;
        logic set;
    } t_pres_op;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
    } t_mex_in;

    typedef struct packed {
        logic [MEX_W-1:0]    mex;
        logic [STATUS_W-1:0] status;
    } t_mex_out;

endpackage

// ----- src/mex_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps

interface mex_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/mex_count_unit.sv -----
// Per-value count memory with saturating read-modify-write.
`timescale 1ns / 1ps

module mex_count_unit
    import mex_pkg::*;
#(
    parameter int VALUE_SPACE = DEF_VALUE_SPACE,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    localparam int VAL_W = $clog2(VALUE_SPACE)
) (
    input  logic             i_clk,
    input  logic             i_clr_en,
    input  logic [VAL_W-1:0] i_clr_addr,
    input  logic             i_rd_en,
    input  logic [VAL_W-1:0] i_rd_addr,
    input  logic             i_upd_en,
    input  logic             i_mode,
    input  logic [VAL_W-1:0] i_wr_addr,
    output t_status          o_status,
    output t_pres_op         o_op
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] mem [VALUE_SPACE];
    logic [COUNT_WIDTH-1:0] r_cnt_q;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic                   upd_wr;
    logic                   wr_en;
    logic [VAL_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    always_comb begin
        o_status = STAT_OK;
        o_op     = '0;
        new_cnt  = r_cnt_q;
        upd_wr   = 1'b0;
        if (i_upd_en) begin
            if (!i_mode) begin
                if (r_cnt_q == COUNT_MAX) begin
                    o_status = STAT_SAT;
                end else begin
                    new_cnt  = r_cnt_q + 1'b1;
                    upd_wr   = 1'b1;
                    o_op.upd = (r_cnt_q == '0);
                    o_op.set = 1'b1;
                end
            end else begin
                if (r_cnt_q == '0) begin
                    o_status = STAT_ABSENT;
                end else begin
                    new_cnt  = r_cnt_q - 1'b1;
                    upd_wr   = 1'b1;
                    // last occurrence gone: value leaves its block
                    o_op.upd = (r_cnt_q == COUNT_WIDTH'(1));
                    o_op.set = 1'b0;
                end
            end
        end
    end

    assign wr_en   = i_clr_en | upd_wr;
    assign wr_addr = i_clr_en ? i_clr_addr : i_wr_addr;
    assign wr_data = i_clr_en ? '0 : new_cnt;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_cnt_q <= mem[i_rd_addr];
        end
    end

endmodule

// ----- src/mex_block_unit.sv -----
// Presence bitmap memory (one row per block), block-full flags and both searches.
`timescale 1ns / 1ps

module mex_block_unit
    import mex_pkg::*;
#(
    parameter int VALUE_SPACE = DEF_VALUE_SPACE,
    parameter int BLOCK_SIZE  = DEF_BLOCK_SIZE,
    localparam int NUM_BLOCKS = (VALUE_SPACE + BLOCK_SIZE - 1) / BLOCK_SIZE,
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
    localparam int COL_W      = $clog2(BLOCK_SIZE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr_en,
    input  logic [BLK_W-1:0] i_clr_row,
    input  logic             i_rd_en,
    input  logic [BLK_W-1:0] i_blk,
    input  logic [COL_W-1:0] i_col,
    input  t_pres_op         i_op,
    input  logic             i_find_en,
    output logic [BLK_W-1:0] o_fb,
    output logic             o_none,
    output logic [COL_W-1:0] o_zero_col
);

    localparam int LAST_SIZE = VALUE_SPACE - (NUM_BLOCKS - 1) * BLOCK_SIZE;
    localparam logic [BLOCK_SIZE-1:0] LAST_MASK = {BLOCK_SIZE{1'b1}} >> (BLOCK_SIZE - LAST_SIZE);

    logic [BLOCK_SIZE-1:0] mem [NUM_BLOCKS];
    logic [BLOCK_SIZE-1:0] r_row_q;
    logic [NUM_BLOCKS-1:0] r_full;
    logic [NUM_BLOCKS-1:0] n_full;
    logic [BLK_W-1:0]      r_fb;
    logic                  r_none;

    logic [BLOCK_SIZE-1:0] new_row;
    logic [BLOCK_SIZE-1:0] row_mask;
    logic [BLK_W-1:0]      fb;
    logic                  none;
    logic                  wr_en;
    logic [BLK_W-1:0]      wr_addr;
    logic [BLOCK_SIZE-1:0] wr_data;
    logic                  rd_en;
    logic [BLK_W-1:0]      rd_addr;

    // row update and full flag of the touched block
    always_comb begin
        new_row        = r_row_q;
        new_row[i_col] = i_op.set;
        row_mask       = (32'(i_blk) == NUM_BLOCKS - 1) ? LAST_MASK : '1;
        n_full         = r_full;
        if (i_find_en && i_op.upd) begin
            n_full[i_blk] = ((new_row | ~row_mask) == '1);
        end
    end

    // lowest block that is not full
    always_comb begin
        fb   = '0;
        none = 1'b1;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
            if (!n_full[i]) begin
                fb   = BLK_W'(i);
                none = 1'b0;
            end
        end
    end

    // lowest free column of the row read back
    always_comb begin
        o_zero_col = '0;
        for (int i = BLOCK_SIZE - 1; i >= 0; i--) begin
            if (!r_row_q[i]) begin
                o_zero_col = COL_W'(i);
            end
        end
    end

    assign wr_en   = i_clr_en | (i_find_en & i_op.upd);
    assign wr_addr = i_clr_en ? i_clr_row : i_blk;
    assign wr_data = i_clr_en ? '0 : new_row;
    assign rd_en   = i_rd_en | i_find_en;
    assign rd_addr = i_find_en ? fb : i_blk;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first: search may read back the row updated in the same cycle
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                r_row_q <= wr_data;
            end else begin
                r_row_q <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_find_en) begin
            r_fb   <= fb;
            r_none <= none;
        end
    end

    assign o_fb   = r_fb;
    assign o_none = r_none;

endmodule

// ----- src/mex_tracking_multiset.sv -----
// Top level of the mex-tracking multiset: sequencer, address split and result register.
//
//  Channel | Dir | Payload       | Transfer
//  i_in    | in  | mode, value   | i_in.valid & i_in.ready
//  o_out   | out | mex, status   | o_out.valid & o_out.ready
//
// One item at a time, in four steps: count memory read, count write plus presence row read,
// row update with block search and row read, then the in-block search.
// The count memory read-modify-write and the presence row memory port set these steps.
// After reset a clearing pass over all VALUE_SPACE count entries runs with i_in.ready low.
// A result waits in the output register; the next item is taken meanwhile and
// its last step holds only while the previous result is still untaken.
`timescale 1ns / 1ps

module mex_tracking_multiset
    import mex_pkg::*;
#(
    parameter int VALUE_SPACE = DEF_VALUE_SPACE,
    parameter int BLOCK_SIZE  = DEF_BLOCK_SIZE,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mex_stream_if.sink   i_in,
    mex_stream_if.source o_out
);

    localparam int NUM_BLOCKS = (VALUE_SPACE + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int VAL_W      = $clog2(VALUE_SPACE);
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int COL_W      = $clog2(BLOCK_SIZE);
    // exact value / BLOCK_SIZE by reciprocal multiply over the input width
    localparam int DIV_SHIFT  = VALUE_W + COL_W;
    localparam int DIV_MULT   = ((1 << DIV_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int PROD_W     = VALUE_W + DIV_SHIFT + 2;

    t_state              r_state;
    t_state              n_state;
    logic [VAL_W-1:0]    r_clr_idx;
    logic [VAL_W-1:0]    n_clr_idx;
    logic                r_mode;
    logic [VALUE_W-1:0]  r_value;
    logic [BLK_W-1:0]    r_blk;
    logic [COL_W-1:0]    r_col;
    t_status             r_status;
    t_pres_op            r_op;
    logic                r_o_valid;
    logic                n_o_valid;
    logic [MEX_W-1:0]    r_o_mex;
    logic [STATUS_W-1:0] r_o_status;

    logic                in_ready;
    logic                clr_en;
    logic                cnt_rd_en;
    logic                cnt_upd_en;
    logic                blk_rd_en;
    logic                find_en;
    logic                out_load;
    logic                accept;
    logic                in_range;
    logic [PROD_W-1:0]   div_prod;
    logic [BLK_W-1:0]    in_blk;
    t_status             cnt_status;
    t_pres_op            cnt_op;
    t_pres_op            row_op;
    logic [BLK_W-1:0]    fb;
    logic                none;
    logic [COL_W-1:0]    zero_col;
    logic [31:0]         mex_full;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (32'(r_clr_idx) == VALUE_SPACE - 1) n_state = ST_IDLE;
            ST_IDLE:  if (i_in.valid) n_state = ST_COUNT;
            ST_COUNT: n_state = ST_ROW;
            ST_ROW:   n_state = ST_SCAN;
            ST_SCAN:  if (!r_o_valid || o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready   = 1'b0;
        clr_en     = 1'b0;
        cnt_rd_en  = 1'b0;
        cnt_upd_en = 1'b0;
        blk_rd_en  = 1'b0;
        find_en    = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_CLEAR: clr_en = 1'b1;
            ST_IDLE: begin
                in_ready  = 1'b1;
                cnt_rd_en = i_in.valid;
            end
            ST_COUNT: begin
                cnt_upd_en = in_range;
                blk_rd_en  = 1'b1;
            end
            ST_ROW:  find_en  = 1'b1;
            ST_SCAN: out_load = !r_o_valid || o_out.ready;
            default: ;
        endcase
    end

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid & in_ready;
    assign in_range   = 32'(r_value) < VALUE_SPACE;
    assign div_prod   = PROD_W'(i_in.payload.value) * PROD_W'(DIV_MULT);
    assign in_blk     = BLK_W'(div_prod >> DIV_SHIFT);
    assign n_clr_idx  = clr_en ? r_clr_idx + 1'b1 : '0;
    assign row_op     = in_range ? r_op : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (out_load) begin
            n_o_valid = 1'b1;
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_in.payload.mode;
            r_value <= i_in.payload.value;
            r_blk   <= in_blk;
        end
        if (cnt_upd_en || blk_rd_en) begin
            r_col    <= COL_W'(32'(r_value) - 32'(r_blk) * 32'(BLOCK_SIZE));
            r_status <= cnt_status;
            r_op     <= cnt_op;
        end
        if (out_load) begin
            r_o_mex    <= MEX_W'(mex_full);
            r_o_status <= r_status;
        end
    end

    assign mex_full = none ? 32'(VALUE_SPACE)
                           : 32'(fb) * 32'(BLOCK_SIZE) + 32'(zero_col);

    assign o_out.valid          = r_o_valid;
    assign o_out.payload.mex    = r_o_mex;
    assign o_out.payload.status = r_o_status;

    mex_count_unit #(
        .VALUE_SPACE (VALUE_SPACE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .i_clk      (i_clk),
        .i_clr_en   (clr_en),
        .i_clr_addr (r_clr_idx),
        .i_rd_en    (cnt_rd_en),
        .i_rd_addr  (VAL_W'(i_in.payload.value)),
        .i_upd_en   (cnt_upd_en),
        .i_mode     (r_mode),
        .i_wr_addr  (VAL_W'(r_value)),
        .o_status   (cnt_status),
        .o_op       (cnt_op)
    );

    mex_block_unit #(
        .VALUE_SPACE (VALUE_SPACE),
        .BLOCK_SIZE  (BLOCK_SIZE)
    ) u_block (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr_en   (clr_en && (32'(r_clr_idx) < NUM_BLOCKS)),
        .i_clr_row  (BLK_W'(r_clr_idx)),
        .i_rd_en    (blk_rd_en),
        .i_blk      (r_blk),
        .i_col      (r_col),
        .i_op       (row_op),
        .i_find_en  (find_en),
        .o_fb       (fb),
        .o_none     (none),
        .o_zero_col (zero_col)
    );

endmodule

// ----- tb/sv/mex_tracking_multiset_tb.sv -----
// Self-checking testbench for the mex-tracking multiset: directed table, random and fill.
`timescale 1ns / 1ps

module mex_tracking_multiset_tb;
    import mex_pkg::*;

    localparam int VS  = DEF_VALUE_SPACE;
    localparam int BS  = DEF_BLOCK_SIZE;
    localparam int CW  = DEF_COUNT_WIDTH;
    localparam int NB  = (VS + BS - 1) / BS;
    localparam int DW  = $clog2(BS) + 1;
    localparam logic [CW-1:0] CMAX = '1;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int N_DIR       = 20;
    localparam int N_RAND      = 240;

    typedef struct {
        logic               mode;
        logic [VALUE_W-1:0] value;
        logic               known;
        logic [MEX_W-1:0]   mex;
        t_status            status;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    mex_stream_if #(.t_payload(t_mex_in))  in_if ();
    mex_stream_if #(.t_payload(t_mex_out)) out_if ();

    mex_tracking_multiset #(
        .VALUE_SPACE(VS),
        .BLOCK_SIZE (BS),
        .COUNT_WIDTH(CW)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // shadow copy of the multiset
    logic [CW-1:0] tally    [VS];
    logic [DW-1:0] distinct [NB];

    t_mex_out pending_mex [$];
    int       fail_count  = 0;
    int       cycle_count = 0;
    logic     stall_on    = 1'b1;

    // typed expectation travelling alongside the payload
    logic             drv_known  = 1'b0;
    logic [MEX_W-1:0] drv_mex    = '0;
    t_status          drv_status = STAT_OK;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int current_mex();
        int base;
        int size;
        for (int b = 0; b < NB; b++) begin
            base = b * BS;
            size = (VS - base > BS) ? BS : VS - base;
            if (int'(distinct[b]) != size) begin
                for (int v = base; v < base + size; v++)
                    if (tally[v] == '0) return v;
            end
        end
        return VS;
    endfunction

    function automatic t_mex_out apply_update(t_mex_in item);
        t_mex_out      res;
        t_status       st;
        int            v;
        int            b;
        logic [CW-1:0] c;
        st = STAT_OK;
        v  = int'(item.value);
        b  = v / BS;
        if (v < VS) begin
            c = tally[v];
            if (item.mode == OP_ADD) begin
                if (c == CMAX) begin
                    st = STAT_SAT;
                end else begin
                    if (c == '0) distinct[b] = distinct[b] + 1'b1;
                    tally[v] = c + 1'b1;
                end
            end else begin
                if (c == '0) begin
                    st = STAT_ABSENT;
                end else begin
                    if (c == 1 && distinct[b] != '0) distinct[b] = distinct[b] - 1'b1;
                    tally[v] = c - 1'b1;
                end
            end
        end
        res.mex    = MEX_W'(current_mex());
        res.status = st;
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // input transfers feed the predictor; output transfers are checked in order
    always @(posedge i_clk) begin
        t_mex_out pred;
        t_mex_out want;
        t_mex_out got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                pred = apply_update(in_if.payload);
                if (drv_known) begin
                    want.mex    = drv_mex;
                    want.status = drv_status;
                    pending_mex = {pending_mex, want};
                end else begin
                    pending_mex = {pending_mex, pred};
                end
            end
            if (out_if.valid && out_if.ready) begin
                got = out_if.payload;
                if (pending_mex.size() == 0) begin
                    $error("unexpected result: mex %0d status %0d", got.mex, got.status);
                    fail_count++;
                end else begin
                    want = pending_mex.pop_front();
                    if (got.mex !== want.mex) begin
                        $error("mex: expected %0d, got %0d", want.mex, got.mex);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_on) out_if.ready = ($urandom_range(99) >= 12);
        else          out_if.ready = 1'b1;
    end

    task automatic send(input logic mode, input int value, input logic known,
                        input int mex, input t_status status);
        @(negedge i_clk);
        while (stall_on && $urandom_range(99) < 12) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         = 1'b1;
        in_if.payload.mode  = mode;
        in_if.payload.value = VALUE_W'(value);
        drv_known           = known;
        drv_mex             = MEX_W'(mex);
        drv_status          = status;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_mex.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_row dir_rows [N_DIR];
        int   order    [VS];
        int   centre;
        int   val;
        int   tmp;
        int   j;
        logic mode;

        in_if.valid   = 1'b0;
        in_if.payload = '0;
        i_rst_n       = 1'b0;
        for (int v = 0; v < VS; v++) tally[v] = '0;
        for (int b = 0; b < NB; b++) distinct[b] = '0;

        // known rows carry the result read straight off the rules
        dir_rows = '{
            '{OP_ADD,    10'd0,    1'b1, 11'd1, STAT_OK},
            '{OP_REMOVE, 10'd0,    1'b1, 11'd0, STAT_OK},
            '{OP_REMOVE, 10'd0,    1'b1, 11'd0, STAT_ABSENT},
            '{OP_REMOVE, 10'd1023, 1'b1, 11'd0, STAT_ABSENT},
            '{OP_ADD,    10'd1023, 1'b1, 11'd0, STAT_OK},
            '{OP_ADD,    10'd1023, 1'b1, 11'd0, STAT_OK},
            '{OP_REMOVE, 10'd1023, 1'b1, 11'd0, STAT_OK},
            '{OP_ADD,    10'd1,    1'b1, 11'd0, STAT_OK},
            '{OP_ADD,    10'd0,    1'b1, 11'd2, STAT_OK},
            '{OP_ADD,    10'd2,    1'b1, 11'd3, STAT_OK},
            '{OP_ADD,    10'd31,   1'b0, 11'd0, STAT_OK},
            '{OP_ADD,    10'd32,   1'b0, 11'd0, STAT_OK},
            '{OP_ADD,    10'd682,  1'b0, 11'd0, STAT_OK},
            '{OP_ADD,    10'd341,  1'b0, 11'd0, STAT_OK},
            '{OP_REMOVE, 10'd1,    1'b1, 11'd1, STAT_OK},
            '{OP_REMOVE, 10'd1023, 1'b0, 11'd0, STAT_OK},
            '{OP_REMOVE, 10'd1023, 1'b0, 11'd0, STAT_OK},
            '{OP_ADD,    10'd512,  1'b0, 11'd0, STAT_OK},
            '{OP_ADD,    10'd1,    1'b0, 11'd0, STAT_OK},
            '{OP_ADD,    10'd3,    1'b0, 11'd0, STAT_OK}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k])
            send(dir_rows[k].mode, int'(dir_rows[k].value), dir_rows[k].known,
                 int'(dir_rows[k].mex), dir_rows[k].status);

        // hold off until the block has caught up completely
        drain();

        for (int k = 0; k < N_RAND; k++) begin
            stall_on = !(k >= 60 && k < 160);
            centre = current_mex();
            tmp    = int'($urandom_range(99));
            if (tmp < 65) begin
                // work around the mex so that it moves across block borders
                val  = centre + int'($urandom_range(12)) - 6;
                val  = (val < 0) ? 0 : (val > VS - 1) ? VS - 1 : val;
                mode = ($urandom_range(99) < 58) ? OP_ADD : OP_REMOVE;
            end else if (tmp < 75) begin
                val  = ($urandom_range(1) != 0) ? VS - 1 : 0;
                mode = 1'($urandom_range(1));
            end else begin
                val  = int'($urandom_range(VS - 1));
                mode = 1'($urandom_range(1));
            end
            send(mode, val, 1'b0, 0, STAT_OK);
        end
        stall_on = 1'b1;

        // fill every value in random order, then knock a few out and back in
        for (int v = 0; v < VS; v++) order[v] = v;
        for (int i = VS - 1; i > 0; i--) begin
            j        = int'($urandom_range(i));
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int v = 0; v < VS; v++) send(OP_ADD, order[v], 1'b0, 0, STAT_OK);
        for (int k = 0; k < 16; k++) begin
            val = int'($urandom_range(VS - 1));
            send(OP_REMOVE, val, 1'b0, 0, STAT_OK);
            send(OP_ADD, val, 1'b0, 0, STAT_OK);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_mex.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/mex_pkg.sv
src/mex_stream_if.sv
src/mex_count_unit.sv
src/mex_block_unit.sv
src/mex_tracking_multiset.sv
tb/sv/mex_tracking_multiset_tb.sv
